[rtl/rvb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvb_pkg
// shared types and constants of the rolling volatility breaker
// ----------------------------------------------------------------------------
package rvb_pkg;

    // width of one operand of the shared multiplier
    localparam int MUL_W = 32;

    // threshold register and its square
    localparam int THR_W = 16;
    localparam int T2_W  = 2 * THR_W;
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd1311;

    // scale of the variance side of the test (two q16 fractions)
    localparam int FRAC_SHIFT = 2 * THR_W;

    // fewest samples that give a nonzero variance
    localparam int MIN_COUNT = 2;

    // beat layout
    localparam int PRICE_FIELD_W = 24;
    localparam int HELD_W        = 4;
    localparam int OUT_DATA_W    = 8;

    // action codes carried on s_tuser
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OLD_SQ,
        ST_NEW_SQ,
        ST_SUM_SQ,
        ST_THR_SQ,
        ST_NSQ_LO,
        ST_NSQ_HI,
        ST_RHS_LO,
        ST_RHS_HI,
        ST_RHS_ADD,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

[rtl/rvb_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvb_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module rvb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 10
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule
`default_nettype wire

[rtl/rvb_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvb_mul
// shared unsigned multiplier with a registered product
// ----------------------------------------------------------------------------
module rvb_mul (
    input  wire logic                         aclk,
    input  wire logic [rvb_pkg::MUL_W-1:0]    op_a,
    input  wire logic [rvb_pkg::MUL_W-1:0]    op_b,
    output logic      [2*rvb_pkg::MUL_W-1:0]  prod_reg
);

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

endmodule
`default_nettype wire

[rtl/rolling_volatility_breaker_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rolling_volatility_breaker_top
// moving window coefficient of variation check with a latched halt
// ----------------------------------------------------------------------------
//  channel  | ports                     | payload
//  ---------+---------------------------+----------------------------------
//  input    | s_tvalid s_tready         | s_tdata: price, s_tuser: action
//  result   | m_tvalid m_tready         | m_tdata: alert, halted, held
//  config   | cfg_valid cfg_ready       | cfg_data: threshold_q16
//
//  a price beat steps through old_sq, new_sq, sum_sq, thr_sq, nsq_lo, nsq_hi,
//  rhs_lo, rhs_hi and rhs_add to done, where it loads the result register;
//  a clear beat goes from idle straight to done; the next beat is taken in
//  idle; the eight products go one after another through the single 32x32
//  multiplier, one issued per cycle, followed by the final add and compare steps
//  reset (aresetn low, synchronous) empties the window and the halt latch
//  and loads the threshold default; the price store itself is not cleared
//  a stalled result holds in the output register, the next beat is taken
//  meanwhile and its result waits in the last sequencer step
// ----------------------------------------------------------------------------
module rolling_volatility_breaker_top #(
    parameter int WINDOW_LEN = 10,
    parameter int PRICE_BITS = 24
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // input beats
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [rvb_pkg::PRICE_FIELD_W-1:0]    s_tdata,   // [23:0] price
    input  wire logic                                 s_tuser,   // [0] action
    // result beats
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic      [rvb_pkg::OUT_DATA_W-1:0]       m_tdata,   // [0] alert, [1] halted,
                                                                 // [5:2] samples_held, zero
    // threshold register
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [rvb_pkg::THR_W-1:0]            cfg_data
);

    localparam int MUL_W  = rvb_pkg::MUL_W;
    localparam int SLOT_W = $clog2(WINDOW_LEN);
    localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W  = PRICE_BITS + $clog2(WINDOW_LEN);
    localparam int SQ_W   = 2 * PRICE_BITS + $clog2(WINDOW_LEN);
    localparam int NSQ_W  = SQ_W + CNT_W;
    localparam int SQS_W  = 2 * SUM_W;
    localparam int RHS_W  = SQS_W + rvb_pkg::T2_W;
    localparam int CMP_W  = (NSQ_W > SQS_W) ? NSQ_W : SQS_W;

    // sequencer
    rvb_pkg::state_t state_reg, state_next;

    // window state
    logic [SLOT_W-1:0]        slot_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [SQ_W-1:0]          sumsq_reg;
    logic                     halt_reg;
    logic [rvb_pkg::THR_W-1:0] thr_reg;

    // beat in flight
    logic                     action_reg;
    logic [PRICE_BITS-1:0]    price_reg;
    logic [PRICE_BITS-1:0]    old_reg;

    // intermediate terms
    logic [SQS_W-1:0]         sq_reg;      // sum squared
    logic [rvb_pkg::T2_W-1:0] t2_reg;      // threshold squared
    logic [NSQ_W-1:0]         acc_reg;     // n times sum of squares
    logic [NSQ_W-1:0]         var_reg;     // n*sumsq - sum^2
    logic [RHS_W-1:0]         rhs_reg;     // sum^2 * thr^2

    // result register
    logic                     m_tvalid_reg;
    logic                     alert_reg;
    logic [rvb_pkg::HELD_W-1:0] held_reg;

    // ram and multiplier hookup
    logic [PRICE_BITS-1:0]    ram_rdata;
    logic                     ram_we;
    logic [MUL_W-1:0]         mul_a;
    logic [MUL_W-1:0]         mul_b;
    logic [2*MUL_W-1:0]       mul_p;

    logic                     full;
    logic [PRICE_BITS-1:0]    old_src;
    logic                     out_free;
    logic                     load_out;
    logic                     over;
    logic [2*MUL_W-1:0]       sumsq_ext;
    logic [2*MUL_W-1:0]       sq_ext;

    assign full      = (count_reg == CNT_W'(WINDOW_LEN));
    assign old_src   = full ? ram_rdata : '0;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign sumsq_ext = (2*MUL_W)'(sumsq_reg);
    assign sq_ext    = (2*MUL_W)'(sq_reg);

    // variance side is var * 2^32 with zero low bits, so only the upper
    // part of the threshold side matters
    assign over = (count_reg >= CNT_W'(rvb_pkg::MIN_COUNT)) &&
                  (CMP_W'(var_reg) > CMP_W'(rhs_reg[RHS_W-1:rvb_pkg::FRAC_SHIFT]));

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = rvb_pkg::OUT_DATA_W'({held_reg, halt_reg, alert_reg});

    // price store, read at the slot about to be overwritten
    rvb_ram #(
        .WIDTH (PRICE_BITS),
        .DEPTH (WINDOW_LEN)
    ) u_window (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (slot_reg),
        .wr_data (price_reg),
        .rd_addr (slot_reg),
        .rd_data (ram_rdata)
    );

    rvb_mul u_mul (
        .aclk     (aclk),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (mul_p)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rvb_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser == rvb_pkg::ACT_CLEAR) ? rvb_pkg::ST_DONE
                                                                 : rvb_pkg::ST_OLD_SQ;
                end
            end
            rvb_pkg::ST_OLD_SQ:  state_next = rvb_pkg::ST_NEW_SQ;
            rvb_pkg::ST_NEW_SQ:  state_next = rvb_pkg::ST_SUM_SQ;
            rvb_pkg::ST_SUM_SQ:  state_next = rvb_pkg::ST_THR_SQ;
            rvb_pkg::ST_THR_SQ:  state_next = rvb_pkg::ST_NSQ_LO;
            rvb_pkg::ST_NSQ_LO:  state_next = rvb_pkg::ST_NSQ_HI;
            rvb_pkg::ST_NSQ_HI:  state_next = rvb_pkg::ST_RHS_LO;
            rvb_pkg::ST_RHS_LO:  state_next = rvb_pkg::ST_RHS_HI;
            rvb_pkg::ST_RHS_HI:  state_next = rvb_pkg::ST_RHS_ADD;
            rvb_pkg::ST_RHS_ADD: state_next = rvb_pkg::ST_DONE;
            rvb_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = rvb_pkg::ST_IDLE;
                end
            end
            default: state_next = rvb_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake, ram write and multiplier operands
    always_comb begin
        s_tready = 1'b0;
        ram_we   = 1'b0;
        load_out = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        case (state_reg)
            rvb_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            rvb_pkg::ST_OLD_SQ: begin
                mul_a = MUL_W'(old_src);
                mul_b = MUL_W'(old_src);
            end
            rvb_pkg::ST_NEW_SQ: begin
                ram_we = 1'b1;
                mul_a  = MUL_W'(price_reg);
                mul_b  = MUL_W'(price_reg);
            end
            rvb_pkg::ST_SUM_SQ: begin
                mul_a = MUL_W'(sum_reg);
                mul_b = MUL_W'(sum_reg);
            end
            rvb_pkg::ST_THR_SQ: begin
                mul_a = MUL_W'(thr_reg);
                mul_b = MUL_W'(thr_reg);
            end
            rvb_pkg::ST_NSQ_LO: begin
                mul_a = MUL_W'(count_reg);
                mul_b = sumsq_ext[MUL_W-1:0];
            end
            rvb_pkg::ST_NSQ_HI: begin
                mul_a = MUL_W'(count_reg);
                mul_b = sumsq_ext[2*MUL_W-1:MUL_W];
            end
            rvb_pkg::ST_RHS_LO: begin
                mul_a = sq_ext[MUL_W-1:0];
                mul_b = MUL_W'(t2_reg);
            end
            rvb_pkg::ST_RHS_HI: begin
                mul_a = sq_ext[2*MUL_W-1:MUL_W];
                mul_b = MUL_W'(t2_reg);
            end
            rvb_pkg::ST_RHS_ADD: begin
                mul_a = '0;
            end
            rvb_pkg::ST_DONE: begin
                load_out = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rvb_pkg::ST_IDLE;
            slot_reg     <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
            sumsq_reg    <= '0;
            halt_reg     <= 1'b0;
            thr_reg      <= rvb_pkg::THRESHOLD_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                thr_reg <= cfg_data;
            end

            if (state_reg == rvb_pkg::ST_NEW_SQ) begin
                // oldest sample leaves, new one enters the sum and the store; its square is added in ST_SUM_SQ
                sumsq_reg <= sumsq_reg - SQ_W'(mul_p);
                sum_reg   <= sum_reg - SUM_W'(old_reg) + SUM_W'(price_reg);
                slot_reg  <= (slot_reg == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_reg + 1'b1;
                if (!full) begin
                    count_reg <= count_reg + 1'b1;
                end
            end

            if (state_reg == rvb_pkg::ST_SUM_SQ) begin
                sumsq_reg <= sumsq_reg + SQ_W'(mul_p);
            end

            if (load_out) begin
                m_tvalid_reg <= 1'b1;
                if (action_reg == rvb_pkg::ACT_CLEAR) begin
                    halt_reg <= 1'b0;
                end else if (over) begin
                    halt_reg <= 1'b1;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            action_reg <= s_tuser;
            price_reg  <= s_tdata[PRICE_BITS-1:0];
        end
        case (state_reg)
            rvb_pkg::ST_OLD_SQ:  old_reg <= old_src;
            rvb_pkg::ST_THR_SQ:  sq_reg  <= SQS_W'(mul_p);
            rvb_pkg::ST_NSQ_LO:  t2_reg  <= rvb_pkg::T2_W'(mul_p);
            rvb_pkg::ST_NSQ_HI:  acc_reg <= NSQ_W'(mul_p);
            rvb_pkg::ST_RHS_LO:  acc_reg <= acc_reg + NSQ_W'({mul_p, {MUL_W{1'b0}}});
            rvb_pkg::ST_RHS_HI: begin
                rhs_reg <= RHS_W'(mul_p);
                var_reg <= acc_reg - NSQ_W'(sq_reg);
            end
            rvb_pkg::ST_RHS_ADD: rhs_reg <= rhs_reg + RHS_W'({mul_p, {MUL_W{1'b0}}});
            default: begin
                old_reg <= old_reg;
            end
        endcase
        if (load_out) begin
            alert_reg <= (action_reg == rvb_pkg::ACT_SAMPLE) && over;
            held_reg  <= rvb_pkg::HELD_W'(count_reg);
        end
    end

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------

    // until the window fills, the write slot tracks the sample count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != CNT_W'(WINDOW_LEN)) |-> (CNT_W'(slot_reg) == count_reg))
        else $error("write slot out of step with sample count");

    // an empty window carries empty sums
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (sum_reg == '0 && sumsq_reg == '0))
        else $error("sums nonzero with no samples held");

    // the halt latch only sets together with an alert beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(halt_reg) |-> (m_tvalid_reg && alert_reg))
        else $error("halt latched without an alert");

    // no new input beat while a finished result is still held in the sequencer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rvb_pkg::ST_DONE && !out_free) |=> !s_tready)
        else $error("input taken while result is stalled");

endmodule
`default_nettype wire

[dv/rolling_volatility_breaker_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_volatility_breaker_top_tb
// drives price and clear beats into the breaker, keeps its own copy of the
// ten-sample window and the halt latch, and checks each result beat against
// the exact coefficient of variation test at the current threshold
// ----------------------------------------------------------------------------
module rolling_volatility_breaker_top_tb;

    localparam int PRICE_FIELD_W = rvb_pkg::PRICE_FIELD_W;
    localparam int HELD_W        = rvb_pkg::HELD_W;
    localparam int OUT_DATA_W    = rvb_pkg::OUT_DATA_W;
    localparam int THR_W         = rvb_pkg::THR_W;
    localparam int MIN_COUNT     = rvb_pkg::MIN_COUNT;
    localparam int FRAC_SHIFT    = rvb_pkg::FRAC_SHIFT;

    localparam int WINDOW       = 10;
    localparam int LIMIT_CYCLES = 400000;
    localparam logic [PRICE_FIELD_W-1:0] PRICE_MAX = {PRICE_FIELD_W{1'b1}};

    typedef struct packed {
        logic             alert;
        logic             halted;
        logic [HELD_W-1:0] held;
    } verdict_t;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [PRICE_FIELD_W-1:0] s_tdata   = '0;
    logic                     s_tuser   = rvb_pkg::ACT_SAMPLE;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]    m_tdata;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [THR_W-1:0]         cfg_data  = '0;

    // mirror of the block state
    logic [63:0]      window_px [WINDOW];
    int               wr_slot   = 0;
    int               n_held    = 0;
    logic [63:0]      run_sum   = '0;
    logic [63:0]      run_sumsq = '0;
    logic             halt_q    = 1'b0;
    logic [THR_W-1:0] thr_q     = rvb_pkg::THRESHOLD_RESET;

    verdict_t pending_verdicts [$];
    int       mismatches    = 0;
    int       cycles        = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;

    rolling_volatility_breaker_top #(
        .WINDOW_LEN (WINDOW),
        .PRICE_BITS (PRICE_FIELD_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("rolling_volatility_breaker_top_tb NOT OK");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // window update or halt clear, and the integer form of std dev over mean > threshold
    task automatic predict_breaker(input logic action, input logic [PRICE_FIELD_W-1:0] price,
                                   output verdict_t v);
        logic [127:0] n_w, sum_w, sumsq_w, thr_w, sq, spread;
        v.alert = 1'b0;
        if (action == rvb_pkg::ACT_CLEAR) begin
            halt_q = 1'b0;
        end else begin
            if (n_held == WINDOW) begin
                run_sum   -= window_px[wr_slot];
                run_sumsq -= window_px[wr_slot] * window_px[wr_slot];
            end else begin
                n_held++;
            end
            window_px[wr_slot] = price;
            run_sum   += window_px[wr_slot];
            run_sumsq += window_px[wr_slot] * window_px[wr_slot];
            wr_slot = (wr_slot == WINDOW - 1) ? 0 : wr_slot + 1;
            n_w     = n_held;
            sum_w   = run_sum;
            sumsq_w = run_sumsq;
            thr_w   = thr_q;
            sq      = sum_w * sum_w;
            spread  = n_w * sumsq_w - sq;
            if (n_held >= MIN_COUNT && (spread << FRAC_SHIFT) > sq * thr_w * thr_w) begin
                v.alert = 1'b1;
                halt_q  = 1'b1;
            end
        end
        v.halted = halt_q;
        v.held   = n_held[HELD_W-1:0];
    endtask

    task automatic send_item(input logic action, input logic [PRICE_FIELD_W-1:0] price);
        verdict_t v;
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= price;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_breaker(action, price, v);
        pending_verdicts.push_back(v);
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        wait_for_results();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        thr_q = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // result beat checker
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat %h", $time, m_tdata);
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tdata[0] !== want.alert || m_tdata[1] !== want.halted ||
                    m_tdata[5:2] !== want.held) begin
                    mismatches++;
                    $display("%0t: expected alert %0d halted %0d held %0d, got %0d %0d %0d",
                             $time, want.alert, want.halted, want.held,
                             m_tdata[0], m_tdata[1], m_tdata[5:2]);
                end
            end
        end
    end

    // default threshold: warm-up, flat window, alert and halt, clear,
    // all-zero full window with wrap, price extremes
    task automatic test_directed_window();
        send_item(rvb_pkg::ACT_SAMPLE, 24'd1000);
        send_item(rvb_pkg::ACT_SAMPLE, 24'd1000);
        send_item(rvb_pkg::ACT_SAMPLE, 24'd1100);
        send_item(rvb_pkg::ACT_SAMPLE, 24'd1000);
        send_item(rvb_pkg::ACT_CLEAR, PRICE_MAX);
        for (int i = 0; i < WINDOW + 1; i++) send_item(rvb_pkg::ACT_SAMPLE, '0);
        send_item(rvb_pkg::ACT_SAMPLE, PRICE_MAX);
        send_item(rvb_pkg::ACT_SAMPLE, PRICE_MAX);
        send_item(rvb_pkg::ACT_CLEAR, '0);
        send_item(rvb_pkg::ACT_SAMPLE, 24'd1);
        send_item(rvb_pkg::ACT_SAMPLE, '0);
        send_item(rvb_pkg::ACT_CLEAR, 24'h5A5A5A);
    endtask

    task automatic test_threshold_extremes();
        write_threshold('0);
        send_item(rvb_pkg::ACT_SAMPLE, 24'd5);
        send_item(rvb_pkg::ACT_SAMPLE, 24'd6);
        send_item(rvb_pkg::ACT_CLEAR, '0);
        for (int i = 0; i < WINDOW; i++) send_item(rvb_pkg::ACT_SAMPLE, PRICE_MAX);
        write_threshold({THR_W{1'b1}});
        send_item(rvb_pkg::ACT_SAMPLE, '0);
        send_item(rvb_pkg::ACT_SAMPLE, 24'd1);
        send_item(rvb_pkg::ACT_SAMPLE, PRICE_MAX);
        send_item(rvb_pkg::ACT_CLEAR, PRICE_MAX);
    endtask

    task automatic pick_threshold();
        case ($urandom_range(0, 3))
            0:       write_threshold(rvb_pkg::THRESHOLD_RESET);
            1:       write_threshold(THR_W'($urandom_range(300, 4000)));
            2:       write_threshold(THR_W'($urandom_range(4000, 24000)));
            default: write_threshold(THR_W'($urandom_range(0, 65535)));
        endcase
    endtask

    // prices mostly jitter around a base, so scores sit near the threshold
    task automatic test_random_traffic(input int items, input int s_pct, input int r_pct);
        logic [31:0] base;
        logic [31:0] p;
        logic [31:0] dev;
        int          mode;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        pick_threshold();
        base = $urandom_range(1, PRICE_MAX);
        for (int i = 0; i < items; i++) begin
            if (i == items / 2) pick_threshold();
            if ($urandom_range(0, 99) < 3)
                base = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300)
                                                   : $urandom_range(1, PRICE_MAX);
            if ($urandom_range(0, 99) < 9) begin
                send_item(rvb_pkg::ACT_CLEAR, PRICE_FIELD_W'($urandom));
            end else begin
                mode = $urandom_range(0, 99);
                if (mode < 65) begin
                    dev = $urandom_range(0, base >> 4);
                    p = $urandom_range(0, 1) ? base + dev : base - dev;
                end else if (mode < 75) begin
                    dev = $urandom_range(0, base >> 2);
                    p = $urandom_range(0, 1) ? base + dev : base - dev;
                end else if (mode < 85) begin
                    p = $urandom & PRICE_MAX;
                end else if (mode < 90) begin
                    p = '0;
                end else if (mode < 95) begin
                    p = PRICE_MAX;
                end else begin
                    p = base;
                end
                if (p > PRICE_MAX) p = PRICE_MAX;
                send_item(rvb_pkg::ACT_SAMPLE, p[PRICE_FIELD_W-1:0]);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_window();
        test_threshold_extremes();
        test_random_traffic(270, 22, 59);
        test_random_traffic(270, 59, 22);
        test_random_traffic(270, 0, 0);
        wait_for_results();
        repeat (30) @(posedge aclk);
        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("rolling_volatility_breaker_top_tb OK");
        end else begin
            $display("rolling_volatility_breaker_top_tb NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
rtl/rvb_pkg.sv
rtl/rvb_ram.sv
rtl/rvb_mul.sv
rtl/rolling_volatility_breaker_top.sv
dv/rolling_volatility_breaker_top_tb.sv
